[hdl/huffman_code_bit_packer_assert.svh]
// Assertion macros of the code packer top level
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// Plain invariant, checked every cycle out of reset
`define HCBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define HCBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/hcbp_pkg.sv]
// Shared constants and types of the code packer
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int SYM_W        = 8;
    localparam int KIND_W       = 2;
    localparam int BYTE_W       = 8;
    localparam int FVB_W        = 3;
    localparam int TABLE_DEPTH  = 256;
    localparam int LEN_LIM      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    // accumulator: up to seven leftover bits plus one full code
    localparam int ACC_W        = CODE_W + BYTE_W;
    localparam int CNT_W        = $clog2(ACC_W + 1);
    localparam int Q_DEPTH      = 2;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int Q_CW         = $clog2(Q_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        K_LOAD   = 2'd0,
        K_ENCODE = 2'd1,
        K_FLUSH  = 2'd2
    } t_kind;

    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_job;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] fill;
    } t_back_stat;

endpackage

[hdl/hcbp_in_if.sv]
// Input item channel: valid/ready plus the item fields
interface hcbp_in_if;
    import hcbp_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SYM_W-1:0]    symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_W-1:0]    code_len;

    modport source (output valid, kind, symbol, code_bits, code_len, input ready);
    modport sink   (input valid, kind, symbol, code_bits, code_len, output ready);
endinterface

[hdl/hcbp_out_if.sv]
// Result item channel: valid/ready plus the packed byte fields
interface hcbp_out_if;
    import hcbp_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic [FVB_W-1:0]   final_valid_bits;
    logic               last;

    modport source (output valid, out_byte, byte_valid, final_valid_bits, last, input ready);
    modport sink   (input valid, out_byte, byte_valid, final_valid_bits, last, output ready);
endinterface

[hdl/hcbp_front.sv]
// Front end: code table, item classification and table lookup stage
module hcbp_front import hcbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbp_in_if.sink     i_in,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_ready
);

    logic [CODE_W+LEN_W-1:0] r_table [TABLE_DEPTH];
    logic [CODE_W+LEN_W-1:0] r_rd;
    logic                    r_s1_valid;
    logic                    n_s1_valid;
    logic                    r_s1_flush;

    logic                    w_acc;
    logic                    w_load;
    logic                    w_take;
    logic [LEN_W-1:0]        w_len_sat;
    logic [CODE_W-1:0]       w_mask;

    assign i_in.ready = !r_s1_valid || i_job_ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_load     = w_acc && (i_in.kind == K_LOAD);
    // unknown kind is dropped here
    assign w_take     = w_acc && ((i_in.kind == K_ENCODE) || (i_in.kind == K_FLUSH));

    assign w_len_sat = (i_in.code_len > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : i_in.code_len;
    assign w_mask    = (w_len_sat >= LEN_W'(CODE_W)) ? '1
                     : ((CODE_W'(1) << w_len_sat) - CODE_W'(1));

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_table[i_in.symbol] <= {i_in.code_bits & w_mask, w_len_sat};
        end
        if (w_take) begin
            r_rd       <= r_table[i_in.symbol];
            r_s1_flush <= (i_in.kind == K_FLUSH);
        end
    end

    assign n_s1_valid = w_take || (r_s1_valid && !i_job_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    assign o_job_valid = r_s1_valid;
    assign o_job.flush = r_s1_flush;
    assign o_job.code  = r_rd[CODE_W+LEN_W-1:LEN_W];
    assign o_job.len   = r_rd[LEN_W-1:0];

endmodule

[hdl/hcbp_queue.sv]
// Short job queue between front and back end
module hcbp_queue import hcbp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_job  i_push,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_job  o_pop,
    input  logic  i_pop_ready
);

    t_job             r_slot [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp;
    logic [Q_AW-1:0]  r_rp;
    logic [Q_CW-1:0]  r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop        = r_slot[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + Q_AW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + Q_AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hdl/hcbp_back.sv]
// Back end: bit accumulator, byte emission and output register
module hcbp_back import hcbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_job_ready,
    hcbp_out_if.source  o_out,
    output t_back_stat  o_stat
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_bstate;

    t_bstate            r_state, n_state;
    logic [ACC_W-1:0]   r_acc, n_acc;     // valid bits left-aligned, zeros below
    logic [CNT_W-1:0]   r_fill, n_fill;

    logic               r_ov;
    logic [BYTE_W-1:0]  r_obyte;
    logic               r_obv;
    logic [FVB_W-1:0]   r_ofvb;
    logic               r_olast;

    logic               w_slot;
    logic               w_pop;
    logic               w_emit;
    logic [BYTE_W-1:0]  w_byte;
    logic               w_bv;
    logic [FVB_W-1:0]   w_fvb;
    logic               w_last;
    logic [CNT_W-1:0]   w_shift;
    logic [CNT_W-1:0]   w_sum;
    logic [CNT_W-1:0]   w_rem;
    logic [ACC_W-1:0]   w_place;

    assign w_slot  = !r_ov || o_out.ready;
    assign w_sum   = r_fill + CNT_W'(i_job.len);
    assign w_shift = CNT_W'(ACC_W) - w_sum;
    assign w_place = ACC_W'(i_job.code) << w_shift;
    assign w_rem   = r_fill - CNT_W'(BYTE_W);

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_fill  = r_fill;
        w_pop   = 1'b0;
        w_emit  = 1'b0;
        w_byte  = r_acc[ACC_W-1 -: BYTE_W];
        w_bv    = 1'b1;
        w_fvb   = '0;
        w_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.flush) begin
                        if (w_slot) begin
                            w_pop  = 1'b1;
                            w_emit = 1'b1;
                            w_bv   = (r_fill != '0);
                            w_fvb  = r_fill[FVB_W-1:0];
                            w_last = 1'b1;
                            n_acc  = '0;
                            n_fill = '0;
                        end
                    end else begin
                        w_pop  = 1'b1;
                        n_acc  = r_acc | w_place;
                        n_fill = w_sum;
                        if (w_sum >= CNT_W'(BYTE_W)) begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    w_last = (w_rem < CNT_W'(BYTE_W));
                    n_acc  = r_acc << BYTE_W;
                    n_fill = w_rem;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_fill  <= n_fill;
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_obyte <= w_byte;
            r_obv   <= w_bv;
            r_ofvb  <= w_fvb;
            r_olast <= w_last;
        end
    end

    assign o_job_ready            = w_pop;
    assign o_out.valid            = r_ov;
    assign o_out.out_byte         = r_obyte;
    assign o_out.byte_valid       = r_obv;
    assign o_out.final_valid_bits = r_ofvb;
    assign o_out.last             = r_olast;
    assign o_stat.idle            = (r_state == S_IDLE);
    assign o_stat.fill            = r_fill;

endmodule

[hdl/huffman_code_bit_packer.sv]
// Top level of the variable-length code packer
//
// Input channel i_in (valid/ready): kind 0 loads one code table entry
// (symbol, code_bits, code_len), kind 1 encodes a symbol, kind 2 flushes.
// Kind 3 is accepted and dropped. Loads give no result.
// Output channel o_out (valid/ready): one packed byte per item, earliest bit
// in bit 7; last marks the final result of an input item. An encode gives
// zero to four bytes, a flush exactly one (byte_valid 0 if nothing was left).
// An encode passes the registered table read and the queue before it reaches
// the back end, which first merges its code into the accumulator and then
// emits its bytes one at a time; a flush emits its result from the idle state.
// The back end takes no new job until it has emitted every byte of an encode,
// as it has a single byte shifter; up to two jobs wait in the queue meanwhile.
// Reset clears the leftover bits, the queue and the output valid flag. The
// code table is not cleared: encode only symbols already loaded.
// When o_out stalls, the back end holds, the queue fills and i_in.ready
// drops; a finished byte waits in the output register.
`include "huffman_code_bit_packer_assert.svh"

module huffman_code_bit_packer import hcbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbp_in_if.sink     i_in,
    hcbp_out_if.source  o_out
);

    logic        w_fj_valid;
    t_job        w_fj;
    logic        w_fj_ready;
    logic        w_bj_valid;
    t_job        w_bj;
    logic        w_bj_ready;
    t_back_stat  w_stat;

    hcbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (w_fj_valid),
        .o_job       (w_fj),
        .i_job_ready (w_fj_ready)
    );

    hcbp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fj_valid),
        .i_push       (w_fj),
        .o_push_ready (w_fj_ready),
        .o_pop_valid  (w_bj_valid),
        .o_pop        (w_bj),
        .i_pop_ready  (w_bj_ready)
    );

    hcbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_bj_valid),
        .i_job       (w_bj),
        .o_job_ready (w_bj_ready),
        .o_out       (o_out),
        .o_stat      (w_stat)
    );

    // leftover bits never reach a full byte once the back end is idle
    `HCBP_ASSERT(a_idle_fill, !w_stat.idle || (w_stat.fill < CNT_W'(BYTE_W)), "idle with a full byte pending")
    // an empty flush item is always a lone last item with no bit count
    `HCBP_ASSERT_IMP(a_empty_flush, o_out.valid && !o_out.byte_valid, o_out.last && (o_out.final_valid_bits == '0), "bad empty flush item")
    // a bit count only appears on the closing item of a flush
    `HCBP_ASSERT_IMP(a_fvb_last, o_out.valid && (o_out.final_valid_bits != '0), o_out.last && o_out.byte_valid, "bit count on a non-final item")

endmodule

[verif/huffman_code_bit_packer_tb.sv]
// Self-checking testbench of the code packer: directed table, then random items per phase
module huffman_code_bit_packer_tb;
    import hcbp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 21;
    localparam int NUM_PHASES      = 4;
    localparam int MAX_REPORTS     = 10;
    localparam int TX_PCT [NUM_PHASES] = '{0, 63, 0, 6};
    localparam int RX_PCT [NUM_PHASES] = '{0, 0, 63, 6};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } t_pack_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [FVB_W-1:0]  fvb;
        logic              last;
    } t_pack_res;

    // n_typed: -1 take the predictor, 0 or 1 the typed-in result count
    typedef struct {
        t_pack_in  item;
        int        n_typed;
        t_pack_res typed;
    } t_stim_row;

    localparam t_pack_res NO_RES = '0;

    logic i_clk;
    logic i_rst_n;

    hcbp_in_if  in_ch ();
    hcbp_out_if out_ch ();

    huffman_code_bit_packer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // packer model state
    logic [CODE_W-1:0] tbl_code [TABLE_DEPTH];
    logic [LEN_W-1:0]  tbl_len  [TABLE_DEPTH];
    logic [6:0]        carry_bits;
    int                carry_cnt;
    t_pack_res         fresh_bytes [$];
    t_pack_res         expected_bytes [$];

    bit                sym_loaded [TABLE_DEPTH];
    logic [SYM_W-1:0]  loaded_syms [$];

    int                mismatches;
    int                tx_idle_pct;
    int                rx_stall_pct;
    int                hold_requests;
    int                cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] low_ones(int n);
        return (64'd1 << n) - 64'd1;
    endfunction

    // works out the bytes one item releases and advances the model
    function automatic void pack_predict(t_pack_in it);
        logic [63:0] acc;
        int          n;
        int          clen;
        t_pack_res   r;
        fresh_bytes.delete();
        if (it.kind == K_LOAD) begin
            clen = (int'(it.code_len) > LEN_LIM) ? LEN_LIM : int'(it.code_len);
            tbl_len[it.symbol]  = LEN_W'(clen);
            tbl_code[it.symbol] = CODE_W'(64'(it.code_bits) & low_ones(clen));
        end else if (it.kind == K_ENCODE) begin
            clen = int'(tbl_len[it.symbol]);
            acc  = (64'(carry_bits) << clen) | 64'(tbl_code[it.symbol]);
            n    = carry_cnt + clen;
            while (n >= BYTE_W) begin
                n = n - BYTE_W;
                r.out_byte   = BYTE_W'(acc >> n);
                r.byte_valid = 1'b1;
                r.fvb        = '0;
                r.last       = (n < BYTE_W);
                fresh_bytes.push_back(r);
            end
            carry_bits = 7'(acc & low_ones(n));
            carry_cnt  = n;
        end else if (it.kind == K_FLUSH) begin
            r.out_byte   = (carry_cnt > 0) ?
                           BYTE_W'({1'b0, carry_bits} << (BYTE_W - carry_cnt)) : '0;
            r.byte_valid = (carry_cnt > 0);
            r.fvb        = FVB_W'(carry_cnt);
            r.last       = 1'b1;
            fresh_bytes.push_back(r);
            carry_bits = '0;
            carry_cnt  = 0;
        end
    endfunction

    // encodes only ever pick symbols already loaded
    function automatic t_pack_in random_item();
        t_pack_in it;
        int       pick;
        it.symbol    = SYM_W'($urandom);
        it.code_bits = $urandom;
        it.code_len  = LEN_W'($urandom);
        pick = $urandom_range(99);
        if (loaded_syms.size() == 0 || pick < 22) begin
            it.kind = K_LOAD;
            pick = $urandom_range(99);
            if (pick < 7)
                it.code_len = '0;
            else if (pick < 15)
                it.code_len = LEN_W'($urandom_range(63, 33));
            else
                it.code_len = LEN_W'($urandom_range(32, 1));
        end else if (pick < 84) begin
            it.kind   = K_ENCODE;
            it.symbol = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        end else if (pick < 95) begin
            it.kind = K_FLUSH;
        end else begin
            it.kind = KIND_NONE;
        end
        return it;
    endfunction

    // offers one item, leaves valid high once it is taken
    task automatic drive_item(t_pack_in it, int n_typed, t_pack_res typed);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        if (it.kind == K_LOAD && !sym_loaded[it.symbol]) begin
            sym_loaded[it.symbol] = 1'b1;
            loaded_syms.push_back(it.symbol);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= it.kind;
        in_ch.symbol    <= it.symbol;
        in_ch.code_bits <= it.code_bits;
        in_ch.code_len  <= it.code_len;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pack_predict(it);
        if (n_typed < 0) begin
            foreach (fresh_bytes[k]) expected_bytes.push_back(fresh_bytes[k]);
        end else if (n_typed > 0) begin
            expected_bytes.push_back(typed);
        end
    endtask

    // sender pause until every expected byte is out, plus a tail
    task automatic settle(int extra);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_requests > holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : byte_check
        t_pack_res got;
        t_pack_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.out_byte, out_ch.byte_valid, out_ch.final_valid_bits,
                    out_ch.last};
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected byte %h bv %b fvb %0d last %b",
                             got.out_byte, got.byte_valid, got.fvb, got.last);
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch exp %h bv %b fvb %0d last %b, got %h %b %0d %b",
                                 want.out_byte, want.byte_valid, want.fvb, want.last,
                                 got.out_byte, got.byte_valid, got.fvb, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL huffman_code_bit_packer");
            $finish;
        end
    end

    initial begin
        t_stim_row dir_rows [$];
        t_pack_in  it;
        int        useful;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = '0;
        in_ch.symbol    = '0;
        in_ch.code_bits = '0;
        in_ch.code_len  = '0;
        carry_bits      = '0;
        carry_cnt       = 0;
        mismatches      = 0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        hold_requests   = 0;
        cycles          = 0;

        // empty flush straight after reset, ignored kind
        dir_rows.push_back('{'{K_FLUSH, 8'h00, 32'h0, 6'd0}, 1, '{8'h00, 1'b0, 3'd0, 1'b1}});
        dir_rows.push_back('{'{KIND_NONE, 8'hFF, 32'hFFFF_FFFF, 6'd63}, 0, NO_RES});
        // empty code appends nothing
        dir_rows.push_back('{'{K_LOAD, 8'h00, 32'h0, 6'd0}, 0, NO_RES});
        dir_rows.push_back('{'{K_ENCODE, 8'h00, 32'h0, 6'd0}, 0, NO_RES});
        dir_rows.push_back('{'{K_FLUSH, 8'h00, 32'h0, 6'd0}, 1, '{8'h00, 1'b0, 3'd0, 1'b1}});
        // over-long length saturates: four full bytes
        dir_rows.push_back('{'{K_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd63}, 0, NO_RES});
        dir_rows.push_back('{'{K_ENCODE, 8'hFF, 32'h0, 6'd0}, -1, NO_RES});
        dir_rows.push_back('{'{K_FLUSH, 8'h00, 32'h0, 6'd0}, 1, '{8'h00, 1'b0, 3'd0, 1'b1}});
        // bits above the length are dropped
        dir_rows.push_back('{'{K_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd1}, 0, NO_RES});
        dir_rows.push_back('{'{K_ENCODE, 8'h01, 32'h0, 6'd0}, 0, NO_RES});
        dir_rows.push_back('{'{K_FLUSH, 8'h00, 32'h0, 6'd0}, 1, '{8'h80, 1'b1, 3'd1, 1'b1}});
        dir_rows.push_back('{'{K_LOAD, 8'h02, 32'h0000_007F, 6'd7}, 0, NO_RES});
        dir_rows.push_back('{'{K_ENCODE, 8'h02, 32'h0, 6'd0}, 0, NO_RES});
        dir_rows.push_back('{'{K_FLUSH, 8'h00, 32'h0, 6'd0}, 1, '{8'hFE, 1'b1, 3'd7, 1'b1}});
        // seven leftover bits plus a full-width code
        dir_rows.push_back('{'{K_ENCODE, 8'h02, 32'h0, 6'd0}, 0, NO_RES});
        dir_rows.push_back('{'{K_ENCODE, 8'hFF, 32'h0, 6'd0}, -1, NO_RES});
        dir_rows.push_back('{'{K_LOAD, 8'h55, 32'hAAAA_AAAA, 6'd33}, 0, NO_RES});
        dir_rows.push_back('{'{K_ENCODE, 8'h55, 32'hFFFF_FFFF, 6'd63}, -1, NO_RES});
        dir_rows.push_back('{'{K_LOAD, 8'h80, 32'hFFFF_FF00, 6'd8}, 0, NO_RES});
        dir_rows.push_back('{'{K_ENCODE, 8'h80, 32'h0, 6'd0}, -1, NO_RES});
        // ignored kind must keep the leftover bits
        dir_rows.push_back('{'{KIND_NONE, 8'h00, 32'h0, 6'd0}, 0, NO_RES});
        dir_rows.push_back('{'{K_FLUSH, 8'h00, 32'h0, 6'd0}, -1, NO_RES});
        dir_rows.push_back('{'{K_LOAD, 8'h03, 32'h0000_0001, 6'd32}, 0, NO_RES});
        dir_rows.push_back('{'{K_ENCODE, 8'h03, 32'h0, 6'd0}, -1, NO_RES});
        dir_rows.push_back('{'{K_FLUSH, 8'h00, 32'h0, 6'd0}, -1, NO_RES});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            drive_item(dir_rows[r].item, dir_rows[r].n_typed, dir_rows[r].typed);
        settle(DRAIN_CYCLES);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            tx_idle_pct  = TX_PCT[ph];
            rx_stall_pct = RX_PCT[ph];
            // long receiver hold-off while items keep coming at full rate
            if (ph == 0) hold_requests++;
            useful = 0;
            while (useful < ITEMS_PER_PHASE) begin
                it = random_item();
                if (it.kind != KIND_NONE) useful++;
                drive_item(it, -1, NO_RES);
            end
            settle(DRAIN_CYCLES);
        end

        if (mismatches == 0) begin
            $display("PASS huffman_code_bit_packer");
        end else begin
            $display("FAIL huffman_code_bit_packer");
        end
        $finish;
    end

endmodule
